// ===== hdl/rsd_pkg.sv =====
`default_nettype none

package rsd_pkg;

    // Frame size limit and derived widths
    localparam int MAX_DIM  = 1024;
    localparam int CFG_W    = 11;
    localparam int DIM_W    = $clog2(2 * MAX_DIM);
    localparam int COL_W    = $clog2(MAX_DIM);
    localparam int SUM_W    = $clog2(MAX_DIM + 256);
    localparam int CMP_W    = (SUM_W > DIM_W) ? SUM_W : DIM_W;
    localparam int ROW_MAX  = 2 * MAX_DIM - 1;
    localparam int PROD_W   = 2 * DIM_W;
    localparam int ADDR_W   = 20;
    localparam int FULL_W   = ((PROD_W > ADDR_W) ? PROD_W : ADDR_W) + 1;
    localparam int RS_W     = ((DIM_W > 8) ? DIM_W : 8) + 1;
    localparam int PAL_AW   = 8;
    localparam int RGB_W    = 24;
    localparam int CFG_IDX_W = 1;

    localparam logic [15:0] HDR_MASK = 16'hC0FF;

    typedef enum logic [1:0] {
        OP_PAL_WRITE   = 2'd0,
        OP_FRAME_START = 2'd1,
        OP_SPRITE      = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        TAG_LITERAL  = 2'b00,
        TAG_ROW_SKIP = 2'b01
    } t_tag;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_EMIT,
        S_ADV
    } t_state;

    typedef struct packed {
        logic [1:0]       op;
        logic [15:0]      data_word;
        logic [PAL_AW-1:0] palette_slot;
        logic [RGB_W-1:0] palette_rgb;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [31:0]       argb;
        logic              out_of_frame;
    } t_out_item;

    // Map a written dimension onto 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end else begin
            return DIM_W'(v);
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rle_sprite_decoder_top.sv =====
// Run-length sprite decoder.
// Input channel (i_in_valid / o_in_stall, payload i_in_data) takes palette
// writes, frame starts and sprite stream words; a transaction completes on a
// rising edge with valid high and stall low. Output channel (o_out_valid /
// i_out_stall, payload o_out_data) carries one pixel per pixel word.
// Frame width and height are written through i_cfg_we / i_cfg_index /
// i_cfg_wdata; the user must do so only while idle, the block does not check.
// Palette writes, frame starts, unknown ops, literal headers and row skips
// complete in the accepting cycle; a pixel-skip header then goes to the
// advance state. A pixel word passes the multiply, emit and advance states;
// its result is loaded into the output register in the emit state, which
// waits until that register is free. The advance state divides by the width
// one row per cycle through a single subtract-and-compare unit.
// Throughput is one word at a time: o_in_stall stays high until the current
// word finishes.
// A stalled receiver holds the result in the output register; the decoder
// keeps taking words and only waits when a second pixel is ready to load.
// Synchronous reset clears position, literal count, output valid and sets
// width and height to 1; palette contents are not cleared.
`default_nettype none

module rle_sprite_decoder_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire rsd_pkg::t_in_item                i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output rsd_pkg::t_out_item                    o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [rsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rsd_pkg::CFG_W-1:0]        i_cfg_wdata
);

    localparam int DIM_W  = rsd_pkg::DIM_W;
    localparam int COL_W  = rsd_pkg::COL_W;
    localparam int SUM_W  = rsd_pkg::SUM_W;
    localparam int CMP_W  = rsd_pkg::CMP_W;
    localparam int PROD_W = rsd_pkg::PROD_W;
    localparam int FULL_W = rsd_pkg::FULL_W;
    localparam int RS_W   = rsd_pkg::RS_W;
    localparam int ADDR_W = rsd_pkg::ADDR_W;

    rsd_pkg::t_state      r_state, n_state;
    logic                 r_out_valid, n_out_valid;
    rsd_pkg::t_out_item   r_out_data, n_out_data;
    logic [COL_W-1:0]     r_col, n_col;
    logic [DIM_W-1:0]     r_row, n_row;
    logic [7:0]           r_run_left, n_run_left;
    logic [DIM_W-1:0]     r_width, n_width;
    logic [DIM_W-1:0]     r_height, n_height;
    logic [SUM_W-1:0]     r_total, n_total;
    logic [DIM_W-1:0]     r_rows_below, n_rows_below;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [3:0]           r_alpha, n_alpha;
    logic                 r_outside, n_outside;

    logic                 in_acc;
    logic                 out_free;
    logic [15:0]          hdr;
    logic [RS_W-1:0]      row_sum;
    logic [DIM_W-1:0]     row_add;
    logic [DIM_W-1:0]     row_inc;
    logic                 total_ge;
    logic [FULL_W-1:0]    addr_sum;
    logic                 pal_we;
    logic                 pal_re;
    logic [rsd_pkg::RGB_W-1:0] pal_rdata;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign hdr      = i_in_data.data_word & rsd_pkg::HDR_MASK;

    // Saturating row adds
    assign row_sum = RS_W'(r_row) + RS_W'(hdr[7:0]);
    assign row_add = (row_sum > RS_W'(rsd_pkg::ROW_MAX)) ? DIM_W'(rsd_pkg::ROW_MAX)
                                                         : row_sum[DIM_W-1:0];
    assign row_inc = (r_row == DIM_W'(rsd_pkg::ROW_MAX)) ? r_row : r_row + DIM_W'(1);

    // Shared subtract/compare unit for division by the width
    assign total_ge = CMP_W'(r_total) >= CMP_W'(r_width);

    // Bottom-up address from the registered product
    assign addr_sum = FULL_W'(r_prod) + FULL_W'(r_col);

    rsd_palette u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_in_data.palette_slot),
        .i_wdata (i_in_data.palette_rgb),
        .i_re    (pal_re),
        .i_raddr (i_in_data.data_word[8:1]),
        .o_rdata (pal_rdata)
    );

    // State and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_run_left  <= '0;
            r_width     <= DIM_W'(1);
            r_height    <= DIM_W'(1);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_col       <= n_col;
            r_row       <= n_row;
            r_run_left  <= n_run_left;
            r_width     <= n_width;
            r_height    <= n_height;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_total      <= n_total;
        r_rows_below <= n_rows_below;
        r_prod       <= n_prod;
        r_alpha      <= n_alpha;
        r_outside    <= n_outside;
    end

    // Sequencer: next state and datapath control
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_col        = r_col;
        n_row        = r_row;
        n_run_left   = r_run_left;
        n_width      = r_width;
        n_height     = r_height;
        n_total      = r_total;
        n_rows_below = r_rows_below;
        n_prod       = r_prod;
        n_alpha      = r_alpha;
        n_outside    = r_outside;
        pal_we       = 1'b0;
        pal_re       = 1'b0;

        // Drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Configuration writes
        if (i_cfg_we) begin
            case (i_cfg_index)
                rsd_pkg::REG_FRAME_WIDTH:  n_width  = rsd_pkg::clamp_dim(i_cfg_wdata);
                rsd_pkg::REG_FRAME_HEIGHT: n_height = rsd_pkg::clamp_dim(i_cfg_wdata);
                default: ;
            endcase
        end

        case (r_state)
            rsd_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.op)
                        rsd_pkg::OP_PAL_WRITE: begin
                            pal_we = 1'b1;
                        end
                        rsd_pkg::OP_FRAME_START: begin
                            n_col      = '0;
                            n_row      = '0;
                            n_run_left = '0;
                        end
                        rsd_pkg::OP_SPRITE: begin
                            if (r_run_left != '0) begin
                                // Pixel word: start palette read and address math
                                pal_re       = 1'b1;
                                n_alpha      = i_in_data.data_word[12:9];
                                n_outside    = r_row >= r_height;
                                n_rows_below = r_height - r_row - DIM_W'(1);
                                n_state      = rsd_pkg::S_MUL;
                            end else begin
                                case (hdr[15:14])
                                    rsd_pkg::TAG_LITERAL:  n_run_left = hdr[7:0];
                                    rsd_pkg::TAG_ROW_SKIP: n_row      = row_add;
                                    default: begin
                                        n_total = SUM_W'(r_col) + SUM_W'(hdr[7:0]);
                                        n_state = rsd_pkg::S_ADV;
                                    end
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
            end
            rsd_pkg::S_MUL: begin
                n_prod  = PROD_W'(r_rows_below) * PROD_W'(r_width);
                n_state = rsd_pkg::S_EMIT;
            end
            rsd_pkg::S_EMIT: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_out_valid                = 1'b1;
                    n_out_data.pixel_address   = r_outside ? '0 : addr_sum[ADDR_W-1:0];
                    n_out_data.argb            = {r_alpha, r_alpha, pal_rdata};
                    n_out_data.out_of_frame    = r_outside;
                    n_run_left                 = r_run_left - 8'd1;
                    n_total                    = SUM_W'(r_col) + SUM_W'(1);
                    n_state                    = rsd_pkg::S_ADV;
                end
            end
            rsd_pkg::S_ADV: begin
                // One row per cycle until the remainder is below the width
                if (total_ge) begin
                    n_total = r_total - SUM_W'(r_width);
                    n_row   = row_inc;
                end else begin
                    n_col   = r_total[COL_W-1:0];
                    n_state = rsd_pkg::S_IDLE;
                end
            end
            default: n_state = rsd_pkg::S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != rsd_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_pixel_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.op == rsd_pkg::OP_SPRITE && r_run_left != '0)
        |=> (r_state == rsd_pkg::S_MUL))
        else $error("pixel word did not enter the multiply step");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= DIM_W'(rsd_pkg::ROW_MAX))
        else $error("row counter passed its saturation limit");

    a_outside_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_of_frame) |-> (o_out_data.pixel_address == '0))
        else $error("out-of-frame pixel carries a nonzero address");

    a_emit_from_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsd_pkg::S_EMIT) |-> ($past(r_state) == rsd_pkg::S_MUL
                                          || $past(r_state) == rsd_pkg::S_EMIT))
        else $error("emit step entered without a product");
`endif

endmodule

`default_nettype wire

// ===== hdl/rsd_palette.sv =====
`default_nettype none

module rsd_palette (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [rsd_pkg::PAL_AW-1:0]    i_waddr,
    input  wire logic [rsd_pkg::RGB_W-1:0]     i_wdata,
    input  wire logic                          i_re,
    input  wire logic [rsd_pkg::PAL_AW-1:0]    i_raddr,
    output logic      [rsd_pkg::RGB_W-1:0]     o_rdata
);

    logic [rsd_pkg::RGB_W-1:0] r_mem [2**rsd_pkg::PAL_AW];
    logic [rsd_pkg::RGB_W-1:0] r_rdata;

    // Write one colour entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
